### hw/rtl/sadvt_pkg.sv
// Shared constants and types for the six-axis damped view tracker.
// No dependencies; used by sadvt_isqrt and the core top level.
package sadvt_pkg;
  localparam int unsigned TickMsDefault = 10;
  localparam int unsigned NumChan = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [15:0] DampQ16 = 16'd58982;
  localparam logic [15:0] GainQ16 = 16'd197;
  localparam logic [15:0] NearScaleQ16 = 16'd52429;
  localparam logic signed [33:0] HalfTurn = 34'sd11796480;
  localparam logic signed [33:0] FullTurn = 34'sd23592960;
  localparam logic signed [33:0] BoxX = 34'sd9830400;
  localparam logic signed [33:0] BoxY = 34'sd5242880;
  localparam logic signed [33:0] BoxZ = 34'sd327680;
  localparam logic [30:0] ClipMax = 31'h7FFFFFFF;
  localparam logic [30:0] OneQ16 = 31'd65536;

  typedef struct packed {
    logic        start;
    logic [65:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [32:0] root;
  } sqrt_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

### hw/rtl/six_axis_damped_view_tracker_core.sv
// Top level of the six-axis damped view tracker: sequencer, shared MAC and clip logic.
// Depends on sadvt_pkg and sadvt_isqrt.
//
//  channel  | direction | payload
//  s_axis   | in        | tdata[15:0] elapsed_ms
//  m_axis   | out       | tdata[255:0] pos_x..fov, near_dist, far_dist
//  cfg      | in        | cfg_idx_i, cfg_data_i goal register write
//
// Sequence: from the input transfer, each whole tick does a heading unwrap, two products
//   per channel on the one shared 34x34 multiplier and a position update; if a tick ran,
//   the clip pass follows: six squares on the same multiplier and two bit-serial roots
//   (three squares and one root inside the near box). Under a tick: straight to the output.
// Reset: all core state returns to its power-up values; the goal registers too.
// Stalls: a finished result waits in SOut while the output register is still full;
//   the input is ready again once the result moves into that register.
module six_axis_damped_view_tracker_core
  import sadvt_pkg::*;
#(
  parameter int unsigned TickMs = TickMsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // [15:0] elapsed_ms
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [127:96] elevation,
  // [159:128] heading, [191:160] fov, [222:192] near_dist, [253:223] far_dist
  output logic [255:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);
  localparam logic [15:0] TickW = 16'(TickMs);

  localparam logic [3:0] SIdle = 4'd0, SCount = 4'd1, SWrap = 4'd2, SMulV = 4'd3,
                         SMulE = 4'd4, SVel = 4'd5, SAdd = 4'd6, SClip = 4'd7,
                         SSqN = 4'd8, SRootN = 4'd9, SNear = 4'd10, SWaitN = 4'd11,
                         SSqF = 4'd12, SRootF = 4'd13, SOut = 4'd14;

  logic [3:0]  st_q, st_d;
  logic signed [31:0] goal_q [NumChan];
  logic signed [31:0] cur_q [NumChan];
  logic signed [31:0] vel_q [NumChan];
  logic [30:0] near_q, far_q;
  logic [15:0] ms_q, ms_d;
  logic [2:0]  ch_q, ch_d;
  logic signed [63:0] acc_q, acc_d;
  logic [65:0] rad_q, rad_d;
  logic        tick_q, tick_d;
  logic signed [33:0] raw_q;
  logic        out_valid_q;
  logic [255:0] out_q;

  logic signed [33:0] a_mul, b_mul;
  logic signed [67:0] prod;
  logic signed [33:0] ax, ay, dz, sq_op;
  logic        inbox;
  logic signed [63:0] rnd, hd;
  logic signed [31:0] head_w;
  sqrt_req_t   sq_req;
  sqrt_rsp_t   sq_rsp;

  assign s_axis_tready = (st_q == SIdle);
  assign cfg_ready_o   = (st_q == SIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Box distances from the current position; pick the operand of each square.
  always_comb begin
    ax = (cur_q[0] < 0) ? -34'(cur_q[0]) : 34'(cur_q[0]);
    ay = (cur_q[1] < 0) ? -34'(cur_q[1]) : 34'(cur_q[1]);
    dz = 34'(cur_q[2]) - BoxZ;
    inbox = (ax < BoxX) && (ay < BoxY);
    if (st_q == SSqF) begin
      unique case (ch_q)
        3'd0:    sq_op = ax + BoxX;
        3'd1:    sq_op = ay + BoxY;
        default: sq_op = 34'(cur_q[2]);
      endcase
    end else begin
      unique case (ch_q)
        3'd0:    sq_op = dz;
        3'd1:    sq_op = (ax >= BoxX) ? ax - BoxX : '0;
        default: sq_op = (ay >= BoxY) ? ay - BoxY : '0;
      endcase
    end
  end

  // Shared multiplier: velocity times damping, error times gain, squares, near scale.
  always_comb begin
    a_mul = 34'(vel_q[ch_q]);
    b_mul = 34'(DampQ16);
    unique case (st_q)
      SMulE: begin
        a_mul = 34'(goal_q[ch_q]) - 34'(cur_q[ch_q]); b_mul = 34'(GainQ16);
      end
      SNear: begin
        a_mul = raw_q; b_mul = 34'(NearScaleQ16);
      end
      SSqN, SSqF: begin
        a_mul = sq_op; b_mul = sq_op;
      end
      default: ;
    endcase
    prod = a_mul * b_mul;
  end

  // Unwrap heading: lower check first, upper sees its result.
  always_comb begin
    head_w = cur_q[4];
    if (34'(goal_q[4]) - 34'(head_w) < -HalfTurn)
      head_w = sat32(64'(head_w) - 64'(FullTurn));
    if (34'(goal_q[4]) - 34'(head_w) > HalfTurn)
      head_w = sat32(64'(head_w) + 64'(FullTurn));
  end

  always_comb begin
    sq_req.radicand = rad_q;
    sq_req.start = ((st_q == SRootN) || (st_q == SRootF)) && !sq_rsp.busy && !sq_rsp.done;
  end

  sadvt_isqrt u_isqrt (.clk_i, .rst_ni, .req_i(sq_req), .rsp_o(sq_rsp));

  always_comb begin
    st_d = st_q; ms_d = ms_q; ch_d = ch_q; acc_d = acc_q; rad_d = rad_q; tick_d = tick_q;
    // Round half up and drop 16 fraction bits; the arithmetic shift floors.
    rnd = acc_q + 64'sd32768;
    hd = rnd >>> 16;
    unique case (st_q)
      SIdle:  if (s_axis_tvalid && s_axis_tready) begin
                ms_d = s_axis_tdata; st_d = SCount;
              end
      SCount: if (ms_q >= TickW) begin
                ms_d = ms_q - TickW; st_d = SWrap;
              end else begin
                st_d = tick_q ? SClip : SOut;
              end
      SWrap:  begin ch_d = '0; st_d = SMulV; end
      SMulV:  begin acc_d = 64'(prod); st_d = SMulE; end
      SMulE:  begin acc_d = acc_q + 64'(prod); st_d = SVel; end
      SVel:   if (ch_q == 3'(NumChan - 1)) st_d = SAdd;
              else begin ch_d = ch_q + 3'd1; st_d = SMulV; end
      SAdd:   begin tick_d = 1'b1; st_d = SCount; end
      SClip:  begin ch_d = '0; rad_d = '0; st_d = inbox ? SNear : SSqN; end
      SSqN:   begin
                rad_d = rad_q + prod[65:0];
                if (ch_q == 3'd2) st_d = SRootN;
                else ch_d = ch_q + 3'd1;
              end
      SRootN: if (sq_rsp.done) st_d = SNear;
      SNear:  begin acc_d = 64'(prod); st_d = SWaitN; end
      SWaitN: begin ch_d = '0; rad_d = '0; st_d = SSqF; end
      SSqF:   begin
                rad_d = rad_q + prod[65:0];
                if (ch_q == 3'd2) st_d = SRootF;
                else ch_d = ch_q + 3'd1;
              end
      SRootF: if (sq_rsp.done) st_d = SOut;
      SOut:   if (!out_valid_q || m_axis_tready) begin
                tick_d = 1'b0; st_d = SIdle;
              end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; ms_q <= '0; ch_q <= '0; acc_q <= '0; rad_q <= '0; tick_q <= 1'b0;
      out_valid_q <= 1'b0; out_q <= '0; raw_q <= '0; near_q <= '0; far_q <= '0;
      goal_q[0] <= 32'sd0; goal_q[1] <= -32'sd18350080; goal_q[2] <= 32'sd9830400;
      goal_q[3] <= 32'sd4051436; goal_q[4] <= 32'sd0; goal_q[5] <= 32'sd2411725;
      cur_q[0] <= 32'sd0; cur_q[1] <= -32'sd18350080; cur_q[2] <= 32'sd9830400;
      cur_q[3] <= 32'sd4051436; cur_q[4] <= 32'sd0; cur_q[5] <= 32'sd0;
      for (int i = 0; i < NumChan; i++) vel_q[i] <= '0;
    end else begin
      st_q <= st_d; ms_q <= ms_d; ch_q <= ch_d; acc_q <= acc_d; rad_q <= rad_d;
      tick_q <= tick_d;
      if (cfg_valid_i && cfg_ready_o && cfg_idx_i < 3'(NumChan))
        goal_q[cfg_idx_i] <= cfg_data_i;
      if (st_q == SWrap) cur_q[4] <= head_w;
      if (st_q == SVel) vel_q[ch_q] <= sat32(hd);
      if (st_q == SAdd)
        for (int i = 0; i < NumChan; i++) cur_q[i] <= sat32(64'(cur_q[i]) + 64'(vel_q[i]));
      if (st_q == SClip) raw_q <= dz;
      if (st_q == SRootN && sq_rsp.done) raw_q <= 34'(sq_rsp.root);
      // Floor the near distance at one, cap it at the 31-bit maximum.
      if (st_q == SWaitN) begin
        if (hd < 64'sd65536) near_q <= OneQ16;
        else if (hd > 64'sd2147483647) near_q <= ClipMax;
        else near_q <= hd[30:0];
      end
      if (st_q == SRootF && sq_rsp.done)
        far_q <= (sq_rsp.root > 33'(ClipMax)) ? ClipMax : sq_rsp.root[30:0];
      // Load the output register once it is free or being emptied this cycle.
      if (st_q == SOut && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
        out_q <= {2'b00, far_q, near_q, cur_q[5], cur_q[4], cur_q[3],
                  cur_q[2], cur_q[1], cur_q[0]};
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != SIdle) |-> !s_axis_tready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(out_q)) else $error("result changed");
  a_near_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(st_q == SWaitN) |-> near_q >= OneQ16) else $error("near below one");
`endif
endmodule

### hw/rtl/sadvt_isqrt.sv
// Bit-serial floor integer square root, one result bit per cycle.
// Depends on sadvt_pkg for the request and response structs.
module sadvt_isqrt
  import sadvt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sqrt_req_t req_i,
  output sqrt_rsp_t rsp_o
);
  logic [65:0] rem_q, rem_d;
  logic [65:0] rad_q, rad_d;
  logic [32:0] root_q, root_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [67:0] trial, cand;

  always_comb begin
    rem_d = rem_q; rad_d = rad_q; root_d = root_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    cand = {rem_q[65:0], rad_q[65:64]};
    trial = cand - {33'd0, root_q, 2'b01};
    if (req_i.start) begin
      rem_d = '0; rad_d = req_i.radicand; root_d = '0; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[63:0], 2'b00};
      if (!trial[67]) begin
        rem_d = trial[65:0]; root_d = {root_q[31:0], 1'b1};
      end else begin
        rem_d = cand[65:0]; root_d = {root_q[31:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd32) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; rad_q <= rad_d; root_q <= root_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;
endmodule
